// ===== rtl/scnp_pkg.sv =====
`timescale 1ns / 1ps

package scnp_pkg;

   localparam int BYTE_WIDTH  = 8;
   localparam int EVENT_WIDTH = 3;
   localparam int PARAM_WIDTH = 2;
   localparam int FIELD_WIDTH = 32;
   localparam int WORD_WIDTH  = 32;

   typedef enum logic [EVENT_WIDTH-1:0] {
      EV_SET        = 3'd0,
      EV_NACK_CMD   = 3'd1,
      EV_NACK_PARAM = 3'd2,
      EV_SEND_ON    = 3'd3,
      EV_SEND_OFF   = 3'd4
   } event_type;

   typedef enum logic [PARAM_WIDTH-1:0] {
      PARAM_PERIOD   = 2'd0,
      PARAM_I_GAIN   = 2'd1,
      PARAM_R_GAIN   = 2'd2,
      PARAM_SETPOINT = 2'd3
   } param_type;

   localparam logic [WORD_WIDTH-1:0] WORD_SEND   = 32'h5345_4E44;
   localparam logic [WORD_WIDTH-1:0] WORD_STOP   = 32'h5354_4F50;
   localparam logic [WORD_WIDTH-1:0] WORD_SET    = 32'h5345_5400;
   localparam logic [WORD_WIDTH-1:0] PREFIX_MASK = 32'hFFFF_FF00;

   localparam logic [BYTE_WIDTH-1:0] CHAR_NUL   = 8'h00;
   localparam logic [BYTE_WIDTH-1:0] CHAR_NL    = 8'h0A;
   localparam logic [BYTE_WIDTH-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [BYTE_WIDTH-1:0] CHAR_DOT   = 8'h2E;
   localparam logic [BYTE_WIDTH-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [BYTE_WIDTH-1:0] CHAR_NINE  = 8'h39;
   localparam logic [BYTE_WIDTH-1:0] CHAR_F     = 8'h46;
   localparam logic [BYTE_WIDTH-1:0] CHAR_I     = 8'h49;
   localparam logic [BYTE_WIDTH-1:0] CHAR_R     = 8'h52;
   localparam logic [BYTE_WIDTH-1:0] CHAR_X     = 8'h58;

endpackage

// ===== rtl/scnp_if.sv =====
`timescale 1ns / 1ps

interface scnp_req_if import scnp_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [BYTE_WIDTH-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface scnp_rsp_if import scnp_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [EVENT_WIDTH-1:0] event_res;
   logic [PARAM_WIDTH-1:0] target_param;
   logic                   is_negative;
   logic [FIELD_WIDTH-1:0] integer_part;
   logic [FIELD_WIDTH-1:0] fraction_part;
   logic [FIELD_WIDTH-1:0] fraction_divisor;
   logic                   send_enabled;

   modport source (output valid, output event_res, output target_param, output is_negative,
                   output integer_part, output fraction_part, output fraction_divisor,
                   output send_enabled, input ready);
   modport sink   (input valid, input event_res, input target_param, input is_negative,
                   input integer_part, input fraction_part, input fraction_divisor,
                   input send_enabled, output ready);
endinterface

// ===== rtl/serial_command_number_parser.sv =====
`timescale 1ns / 1ps
// An accepted byte is held in the byte register, then decoded into the event register on the rsp side.
// Throughput: one byte per cycle while the rsp side is not stalled; the byte register feeds a single
// decode and times-ten accumulate step that writes the event register directly.
// Bytes that produce no event (command bytes before the fourth, digits before the dot, leading minus
// signs) use no rsp beat. Synchronous active-high reset clears the parser to command collection.

module serial_command_number_parser
   import scnp_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
) (
   input logic       clock,
   input logic       reset,
   scnp_req_if.sink  req_if,
   scnp_rsp_if.source rsp_if
);

   typedef enum logic [1:0] {
      MODE_CMD  = 2'd0,
      MODE_SIGN = 2'd1,
      MODE_INT  = 2'd2,
      MODE_FRAC = 2'd3
   } mode_type;

   logic                   in_valid_ff;
   logic [BYTE_WIDTH-1:0]  in_byte_ff;

   mode_type               mode_ff, mode_in;
   logic [1:0]             cnt_ff, cnt_in;
   logic [WORD_WIDTH-1:0]  word_ff, word_in;
   logic [PARAM_WIDTH-1:0] param_ff, param_in;
   logic                   send_ff, send_in;
   logic                   minus_ff, minus_in;
   logic [VALUE_WIDTH-1:0] int_ff, int_in;
   logic [VALUE_WIDTH-1:0] frac_ff, frac_in;
   logic [VALUE_WIDTH-1:0] div_ff, div_in;

   logic                   out_valid_ff, out_valid_in;
   logic [EVENT_WIDTH-1:0] out_event_ff;
   logic [PARAM_WIDTH-1:0] out_param_ff;
   logic                   out_neg_ff;
   logic [FIELD_WIDTH-1:0] out_int_ff, out_frac_ff, out_div_ff;
   logic                   out_send_ff;

   logic                   advance;
   logic                   has_res;
   logic                   with_val;
   event_type              ev;
   logic                   is_term, is_digit;
   logic [VALUE_WIDTH-1:0] digit_val;
   logic [WORD_WIDTH-1:0]  word_full;
   logic [63:0]            int_wide, frac_wide, div_wide;

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;

   assign is_term   = (in_byte_ff == CHAR_NUL) || (in_byte_ff == CHAR_NL);
   assign is_digit  = (in_byte_ff >= CHAR_ZERO) && (in_byte_ff <= CHAR_NINE);
   assign digit_val = VALUE_WIDTH'(in_byte_ff - CHAR_ZERO);
   assign word_full = word_ff | (WORD_WIDTH'(in_byte_ff) << {2'd3 - cnt_ff, 3'b000});

   always_comb begin
      mode_in  = mode_ff;
      cnt_in   = cnt_ff;
      word_in  = word_ff;
      param_in = param_ff;
      send_in  = send_ff;
      minus_in = minus_ff;
      int_in   = int_ff;
      frac_in  = frac_ff;
      div_in   = div_ff;
      has_res  = 1'b0;
      with_val = 1'b0;
      ev       = EV_SET;
      case (mode_ff)
         MODE_CMD: begin
            if (!is_term) begin
               word_in = word_full;
               cnt_in  = cnt_ff + 2'd1;
               if (cnt_ff == 2'd3) begin
                  word_in = '0;
                  cnt_in  = 2'd0;
                  if (word_full == WORD_SEND) begin
                     send_in = 1'b1;
                     has_res = 1'b1;
                     ev      = EV_SEND_ON;
                  end else if (word_full == WORD_STOP) begin
                     send_in = 1'b0;
                     has_res = 1'b1;
                     ev      = EV_SEND_OFF;
                  end else if ((word_full & PREFIX_MASK) == WORD_SET) begin
                     int_in   = '0;
                     frac_in  = '0;
                     div_in   = VALUE_WIDTH'(1);
                     minus_in = 1'b0;
                     mode_in  = MODE_SIGN;
                     case (word_full[BYTE_WIDTH-1:0])
                        CHAR_F:  param_in = PARAM_PERIOD;
                        CHAR_I:  param_in = PARAM_I_GAIN;
                        CHAR_R:  param_in = PARAM_R_GAIN;
                        CHAR_X:  param_in = PARAM_SETPOINT;
                        default: begin
                           mode_in = MODE_CMD;
                           has_res = 1'b1;
                           ev      = EV_NACK_PARAM;
                        end
                     endcase
                  end else begin
                     has_res = 1'b1;
                     ev      = EV_NACK_CMD;
                  end
               end
            end
         end
         MODE_SIGN, MODE_INT: begin
            if (mode_ff == MODE_SIGN && in_byte_ff == CHAR_MINUS) begin
               minus_in = 1'b1;
            end else begin
               mode_in = MODE_INT;
               if (is_digit) begin
                  int_in = (int_ff << 3) + (int_ff << 1) + digit_val;
               end else begin
                  has_res  = 1'b1;
                  with_val = 1'b1;
                  if (in_byte_ff == CHAR_DOT) begin
                     mode_in = MODE_FRAC;
                  end else if (is_term) begin
                     mode_in = MODE_CMD;
                     cnt_in  = 2'd0;
                  end else begin
                     // stray byte opens the next command word
                     mode_in = MODE_CMD;
                     word_in = {in_byte_ff, 24'h0};
                     cnt_in  = 2'd1;
                  end
               end
            end
         end
         default: begin
            has_res  = 1'b1;
            with_val = 1'b1;
            if (is_digit) begin
               frac_in = (frac_ff << 3) + (frac_ff << 1) + digit_val;
               div_in  = (div_ff << 3) + (div_ff << 1);
            end else if (is_term) begin
               mode_in = MODE_CMD;
               cnt_in  = 2'd0;
            end else begin
               mode_in = MODE_CMD;
               word_in = {in_byte_ff, 24'h0};
               cnt_in  = 2'd1;
            end
         end
      endcase
   end

   assign int_wide  = 64'(int_in);
   assign frac_wide = 64'(frac_in);
   assign div_wide  = 64'(div_in);

   always_comb begin
      if (advance) begin
         out_valid_in = has_res;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mode_ff      <= MODE_CMD;
         cnt_ff       <= 2'd0;
         word_ff      <= '0;
         param_ff     <= PARAM_PERIOD;
         send_ff      <= 1'b0;
         minus_ff     <= 1'b0;
         int_ff       <= '0;
         frac_ff      <= '0;
         div_ff       <= VALUE_WIDTH'(1);
      end else begin
         out_valid_ff <= out_valid_in;
         if (req_if.ready) begin
            in_valid_ff <= req_if.valid;
         end
         if (advance) begin
            mode_ff  <= mode_in;
            cnt_ff   <= cnt_in;
            word_ff  <= word_in;
            param_ff <= param_in;
            send_ff  <= send_in;
            minus_ff <= minus_in;
            int_ff   <= int_in;
            frac_ff  <= frac_in;
            div_ff   <= div_in;
         end
      end
      if (req_if.ready && req_if.valid) begin
         in_byte_ff <= req_if.rx_byte;
      end
      if (advance && has_res) begin
         out_event_ff <= ev;
         out_param_ff <= with_val ? param_in : '0;
         out_neg_ff   <= with_val && minus_in;
         out_int_ff   <= with_val ? int_wide[FIELD_WIDTH-1:0] : '0;
         out_frac_ff  <= with_val ? frac_wide[FIELD_WIDTH-1:0] : '0;
         out_div_ff   <= with_val ? div_wide[FIELD_WIDTH-1:0] : '0;
         out_send_ff  <= send_in;
      end
   end

   assign rsp_if.valid            = out_valid_ff;
   assign rsp_if.event_res        = out_event_ff;
   assign rsp_if.target_param     = out_param_ff;
   assign rsp_if.is_negative      = out_neg_ff;
   assign rsp_if.integer_part     = out_int_ff;
   assign rsp_if.fraction_part    = out_frac_ff;
   assign rsp_if.fraction_divisor = out_div_ff;
   assign rsp_if.send_enabled     = out_send_ff;

   // drop value fields on every non-set event
   a_nonset_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_event_ff != EV_SET) |->
         (out_int_ff == '0 && out_frac_ff == '0 && out_div_ff == '0 && !out_neg_ff))
      else $error("non-set event carries value fields");

   a_send_on: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_event_ff == EV_SEND_ON) |-> out_send_ff)
      else $error("send started without send flag");

   a_send_off: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_event_ff == EV_SEND_OFF) |-> !out_send_ff)
      else $error("send stopped with send flag set");

   a_hold_state: assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(mode_ff) && $stable(cnt_ff) && $stable(int_ff)))
      else $error("parser state moved without a processed byte");

   a_word_clear: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_CMD && cnt_ff == 2'd0) |-> (word_ff == '0))
      else $error("command word not clear at start of command");

endmodule

// ===== sim/tb_serial_command_number_parser.sv =====
`timescale 1ns / 1ps

module tb_serial_command_number_parser import scnp_pkg::*; ();

   localparam int VALUE_WIDTH    = 32;
   localparam int RANDOM_BYTES   = 900;
   localparam int TAIL_BYTES     = 120;
   localparam int HOLD_AFTER     = 300;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 20;

   // parser phases past command collection
   localparam logic [2:0] PH_CMD_FULL = 3'd4;
   localparam logic [2:0] PH_SIGN     = 3'd5;
   localparam logic [2:0] PH_INT      = 3'd6;
   localparam logic [2:0] PH_FRAC     = 3'd7;

   typedef struct {
      event_type              ev;
      param_type              param;
      logic                   negative;
      logic [FIELD_WIDTH-1:0] int_part;
      logic [FIELD_WIDTH-1:0] frac_part;
      logic [FIELD_WIDTH-1:0] divisor;
      logic                   sending;
   } parser_event_type;

   logic clock;
   logic reset;

   scnp_req_if req_bus ();
   scnp_rsp_if rsp_bus ();

   serial_command_number_parser #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) i_dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_bus),
      .rsp_if(rsp_bus)
   );

   logic [BYTE_WIDTH-1:0] pending_bytes [$];
   parser_event_type      expected_events [$];

   // shadow copy of the parser state
   logic [2:0]             phase;
   logic [WORD_WIDTH-1:0]  cmd_word;
   param_type              sel_param;
   logic                   send_flag;
   logic [VALUE_WIDTH-1:0] int_acc;
   logic [VALUE_WIDTH-1:0] frac_acc;
   logic [VALUE_WIDTH-1:0] div_acc;
   logic                   minus_seen;

   int mismatches;
   int bytes_accepted;
   int idle_cycles;
   int event_count [5];
   int src_gap;
   int sink_gap;
   int hold_count;
   bit hold_done;

   function automatic bit is_term(input logic [BYTE_WIDTH-1:0] b);
      return b == CHAR_NUL || b == CHAR_NL;
   endfunction

   function automatic bit is_digit(input logic [BYTE_WIDTH-1:0] b);
      return b >= CHAR_ZERO && b <= CHAR_NINE;
   endfunction

   function automatic bit tail_phase();
      return pending_bytes.size() < TAIL_BYTES;
   endfunction

   task automatic push_event(input event_type ev, input bit with_value);
      parser_event_type e;
      e.ev        = ev;
      e.param     = with_value ? sel_param : PARAM_PERIOD;
      e.negative  = with_value ? minus_seen : 1'b0;
      e.int_part  = with_value ? FIELD_WIDTH'(int_acc) : '0;
      e.frac_part = with_value ? FIELD_WIDTH'(frac_acc) : '0;
      e.divisor   = with_value ? FIELD_WIDTH'(div_acc) : '0;
      e.sending   = send_flag;
      expected_events.push_back(e);
   endtask

   task automatic start_command(input logic [BYTE_WIDTH-1:0] b);
      cmd_word = WORD_WIDTH'(b) << 24;
      phase    = 3'd1;
   endtask

   task automatic predict_byte(input logic [BYTE_WIDTH-1:0] b);
      logic [WORD_WIDTH-1:0] w;
      if (phase < PH_CMD_FULL) begin
         if (!is_term(b)) begin
            cmd_word = cmd_word | (WORD_WIDTH'(b) << (8 * (3 - int'(phase))));
            phase    = phase + 3'd1;
         end
         if (phase == PH_CMD_FULL) begin
            w        = cmd_word;
            cmd_word = '0;
            phase    = '0;
            if (w == WORD_SEND) begin
               send_flag = 1'b1;
               push_event(EV_SEND_ON, 1'b0);
            end else if (w == WORD_STOP) begin
               send_flag = 1'b0;
               push_event(EV_SEND_OFF, 1'b0);
            end else if ((w & PREFIX_MASK) == WORD_SET) begin
               int_acc    = '0;
               frac_acc   = '0;
               div_acc    = VALUE_WIDTH'(1);
               minus_seen = 1'b0;
               phase      = PH_SIGN;
               case (w[BYTE_WIDTH-1:0])
                  CHAR_F: sel_param = PARAM_PERIOD;
                  CHAR_I: sel_param = PARAM_I_GAIN;
                  CHAR_R: sel_param = PARAM_R_GAIN;
                  CHAR_X: sel_param = PARAM_SETPOINT;
                  default: begin
                     // keep the old selection, back to command collection
                     phase = '0;
                     push_event(EV_NACK_PARAM, 1'b0);
                  end
               endcase
            end else begin
               push_event(EV_NACK_CMD, 1'b0);
            end
         end
      end else if (phase == PH_SIGN && b == CHAR_MINUS) begin
         minus_seen = 1'b1;
      end else begin
         if (phase == PH_SIGN) phase = PH_INT;
         if (phase == PH_INT) begin
            if (is_digit(b)) begin
               int_acc = int_acc * 10 + VALUE_WIDTH'(b - CHAR_ZERO);
            end else begin
               if (b == CHAR_DOT) phase = PH_FRAC;
               else if (is_term(b)) phase = '0;
               else start_command(b);
               push_event(EV_SET, 1'b1);
            end
         end else begin
            // fraction phase: every byte emits the value
            if (is_digit(b)) begin
               frac_acc = frac_acc * 10 + VALUE_WIDTH'(b - CHAR_ZERO);
               div_acc  = div_acc * 10;
            end else if (is_term(b)) begin
               phase = '0;
            end else begin
               start_command(b);
            end
            push_event(EV_SET, 1'b1);
         end
      end
   endtask

   task automatic check_field(input string fname, input logic [FIELD_WIDTH-1:0] exp_val,
                              input logic [FIELD_WIDTH-1:0] act_val);
      if (act_val !== exp_val) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, exp_val,
                  act_val);
      end
   endtask

   task automatic check_event();
      parser_event_type e;
      if (expected_events.size() == 0) begin
         mismatches++;
         $display("%0t: unexpected event beat, expected none, actual event %0d", $time,
                  rsp_bus.event_res);
         return;
      end
      e = expected_events.pop_front();
      event_count[e.ev]++;
      check_field("event_res", FIELD_WIDTH'(e.ev), FIELD_WIDTH'(rsp_bus.event_res));
      check_field("target_param", FIELD_WIDTH'(e.param), FIELD_WIDTH'(rsp_bus.target_param));
      check_field("is_negative", FIELD_WIDTH'(e.negative), FIELD_WIDTH'(rsp_bus.is_negative));
      check_field("integer_part", e.int_part, rsp_bus.integer_part);
      check_field("fraction_part", e.frac_part, rsp_bus.fraction_part);
      check_field("fraction_divisor", e.divisor, rsp_bus.fraction_divisor);
      check_field("send_enabled", FIELD_WIDTH'(e.sending), FIELD_WIDTH'(rsp_bus.send_enabled));
   endtask

   // ---------------- stimulus ----------------

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) pending_bytes.push_back(s[i]);
   endtask

   function automatic logic [BYTE_WIDTH-1:0] rand_digit();
      return CHAR_ZERO + BYTE_WIDTH'($urandom_range(0, 9));
   endfunction

   function automatic logic [BYTE_WIDTH-1:0] rand_nonterm();
      logic [BYTE_WIDTH-1:0] b;
      do b = BYTE_WIDTH'($urandom_range(0, 255)); while (is_term(b));
      return b;
   endfunction

   function automatic logic [BYTE_WIDTH-1:0] rand_stray();
      logic [BYTE_WIDTH-1:0] b;
      do b = BYTE_WIDTH'($urandom_range(0, 255));
      while (is_term(b) || is_digit(b) || b == CHAR_DOT || b == CHAR_MINUS);
      return b;
   endfunction

   task automatic push_digits(input int count);
      repeat (count) pending_bytes.push_back(rand_digit());
   endtask

   function automatic int digit_count();
      // mostly short numbers, now and then long enough to wrap
      return ($urandom_range(0, 7) == 0) ? $urandom_range(10, 16) : $urandom_range(0, 5);
   endfunction

   task automatic gen_set_command();
      logic [BYTE_WIDTH-1:0] letter;
      logic [BYTE_WIDTH-1:0] letters [4];
      letters = '{CHAR_F, CHAR_I, CHAR_R, CHAR_X};
      push_text("SET");
      letter = ($urandom_range(0, 9) == 0) ? rand_nonterm() : letters[$urandom_range(0, 3)];
      pending_bytes.push_back(letter);
      if (!(letter inside {CHAR_F, CHAR_I, CHAR_R, CHAR_X})) return;
      if ($urandom_range(0, 1)) repeat ($urandom_range(1, 3)) pending_bytes.push_back(CHAR_MINUS);
      push_digits(digit_count());
      if ($urandom_range(0, 4) < 3) begin
         pending_bytes.push_back(CHAR_DOT);
         push_digits(digit_count());
      end
      case ($urandom_range(0, 3))
         0: pending_bytes.push_back(CHAR_NL);
         1: pending_bytes.push_back(CHAR_NUL);
         2: push_text($urandom_range(0, 1) ? "SEND" : "STOP");
         default: begin
            pending_bytes.push_back(rand_stray());
            repeat (3) pending_bytes.push_back(rand_nonterm());
         end
      endcase
   endtask

   task automatic gen_send_stop();
      string word;
      word = $urandom_range(0, 1) ? "SEND" : "STOP";
      for (int i = 0; i < 4; i++) begin
         if ($urandom_range(0, 5) == 0)
            pending_bytes.push_back($urandom_range(0, 1) ? CHAR_NUL : CHAR_NL);
         pending_bytes.push_back(word[i]);
      end
   endtask

   task automatic gen_noise();
      repeat (4 * $urandom_range(1, 2)) pending_bytes.push_back(rand_nonterm());
   endtask

   task automatic gen_near_miss();
      string word;
      int pos;
      word = $urandom_range(0, 1) ? "SEND" : "STOP";
      pos  = $urandom_range(0, 3);
      for (int i = 0; i < 4; i++)
         pending_bytes.push_back(i == pos ? rand_nonterm() : word[i]);
   endtask

   task automatic build_stimulus();
      int pick;
      // SEND with skipped NUL and newline
      push_text("S");
      pending_bytes.push_back(CHAR_NUL);
      push_text("E");
      pending_bytes.push_back(CHAR_NL);
      push_text("ND");
      // repeated minus, dot, fraction digit, stray byte opening STOP
      push_text("SETX--9.5STOP");
      push_text("SETQ");
      // high bytes in a command word
      pending_bytes.push_back(8'hFF);
      pending_bytes.push_back(8'h80);
      pending_bytes.push_back(CHAR_NUL);
      pending_bytes.push_back(8'h7F);
      push_text("A");
      // stop while stopped, send while sending
      push_text("STOPSENDSEND");
      push_text("SETF0");
      pending_bytes.push_back(CHAR_NL);
      push_text("SETI9");
      pending_bytes.push_back(CHAR_NUL);
      push_text("SETR.9");
      pending_bytes.push_back(CHAR_NL);

      pick = pending_bytes.size() + RANDOM_BYTES;
      while (pending_bytes.size() < pick) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: gen_set_command();
            11, 12, 13, 14:                    gen_send_stop();
            15, 16:                            gen_noise();
            default:                           gen_near_miss();
         endcase
      end
   endtask

   // ---------------- clock, reset, run control ----------------

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.rx_byte    = '0;
      rsp_bus.ready      = 1'b0;
      phase              = '0;
      cmd_word           = '0;
      sel_param          = PARAM_PERIOD;
      send_flag          = 1'b0;
      int_acc            = '0;
      frac_acc           = '0;
      div_acc            = VALUE_WIDTH'(1);
      minus_seen         = 1'b0;
      mismatches         = 0;
      bytes_accepted     = 0;
      idle_cycles        = 0;
      event_count        = '{default: 0};
      build_stimulus();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      do @(posedge clock); while (pending_bytes.size() > 0 || req_bus.valid);
      do @(posedge clock); while (expected_events.size() > 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d bytes: %0d set events, %0d command nacks, %0d parameter nacks,",
               bytes_accepted, event_count[EV_SET], event_count[EV_NACK_CMD],
               event_count[EV_NACK_PARAM]);
      $display("%0d send-on and %0d send-off events; %0d mismatches.",
               event_count[EV_SEND_ON], event_count[EV_SEND_OFF], mismatches);
      if (mismatches == 0)
         $display("tb_serial_command_number_parser passed");
      else
         $display("tb_serial_command_number_parser failed");
      $finish;
   end

   // ---------------- driver ----------------

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid   <= 1'b0;
         req_bus.rx_byte <= '0;
         src_gap         <= 0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (src_gap > 0) begin
            src_gap       <= src_gap - 1;
            req_bus.valid <= 1'b0;
         end else if (pending_bytes.size() == 0) begin
            req_bus.valid <= 1'b0;
         end else if (!tail_phase() && $urandom_range(0, 11) == 0) begin
            src_gap       <= $urandom_range(0, 17);
            req_bus.valid <= 1'b0;
         end else begin
            req_bus.valid   <= 1'b1;
            req_bus.rx_byte <= pending_bytes.pop_front();
         end
      end
   end

   // ---------------- receiver ready ----------------

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         sink_gap      <= 0;
         hold_count    <= 0;
         hold_done     <= 1'b0;
      end else if (hold_count > 0) begin
         hold_count    <= hold_count - 1;
         rsp_bus.ready <= 1'b0;
      end else if (!hold_done && bytes_accepted >= HOLD_AFTER) begin
         // long back-pressure: let the parser fill and stall its input
         hold_count    <= HOLD_CYCLES - 1;
         hold_done     <= 1'b1;
         rsp_bus.ready <= 1'b0;
      end else if (sink_gap > 0) begin
         sink_gap      <= sink_gap - 1;
         rsp_bus.ready <= 1'b0;
      end else if (!tail_phase() && $urandom_range(0, 9) == 0) begin
         sink_gap      <= $urandom_range(0, 17);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // ---------------- monitor ----------------

   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            predict_byte(req_bus.rx_byte);
            bytes_accepted++;
         end
         if (rsp_bus.valid && rsp_bus.ready) check_event();
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat for %0d cycles, %0d events outstanding", $time,
                     idle_cycles, expected_events.size());
            $display("tb_serial_command_number_parser failed");
            $finish;
         end
      end
   end

endmodule
